FILE: hw/rtl/bts_pkg.sv
// shared types, codes and constants for the banded thermostat
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

   // result event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_ENTRY   = 3'd1;
   localparam logic [2:0] EV_ECHO    = 3'd2;
   localparam logic [2:0] EV_ACCEPT  = 3'd3;
   localparam logic [2:0] EV_REJECT  = 3'd4;
   localparam logic [2:0] EV_CONTROL = 3'd5;

   // drive bands
   localparam logic [2:0] BAND_HEAT = 3'd0;
   localparam logic [2:0] BAND_OFF  = 3'd1;
   localparam logic [2:0] BAND_LOW  = 3'd2;
   localparam logic [2:0] BAND_MED  = 3'd3;
   localparam logic [2:0] BAND_HIGH = 3'd4;

   localparam logic [7:0] DUTY_LOW  = 8'd85;
   localparam logic [7:0] DUTY_MED  = 8'd170;
   localparam logic [7:0] DUTY_HIGH = 8'd255;

   localparam logic [5:0] SETPOINT_RESET = 6'd26;
   localparam logic [6:0] SETPOINT_MIN   = 7'd10;
   localparam logic [6:0] SETPOINT_MAX   = 7'd50;

   typedef struct packed {
      logic [2:0] evt;
      logic [7:0] echo;
      logic [5:0] setpoint;
      logic       control;
   } entry_res_type;

   function automatic logic [7:0] duty_of_band(input logic [2:0] band);
      logic [7:0] duty;
      case (band)
         BAND_LOW:  duty = DUTY_LOW;
         BAND_MED:  duty = DUTY_MED;
         BAND_HIGH: duty = DUTY_HIGH;
         default:   duty = 8'd0;
      endcase
      return duty;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bts_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface bts_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] serial_byte;
   logic [9:0] sensor_sample;

   modport source (output valid, command, serial_byte, sensor_sample, input ready);
   modport sink (input valid, command, serial_byte, sensor_sample, output ready);
endinterface

interface bts_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       heater_on;
   logic       fan_on;
   logic [7:0] fan_duty;
   logic [2:0] fan_band;
   logic [8:0] temperature_c;
   logic [5:0] setpoint_c;
   logic [7:0] echo_byte;

   modport source (output valid, event_res, heater_on, fan_on, fan_duty, fan_band,
                   temperature_c, setpoint_c, echo_byte, input ready);
   modport sink (input valid, event_res, heater_on, fan_on, fan_duty, fan_band,
                 temperature_c, setpoint_c, echo_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/banded_thermostat_with_setpoint_entry_core.sv
// banded thermostat with serial setpoint entry, top level
//
// req_ch carries one request per handshake: a received serial byte (command 0)
// or a 10-bit sensor sample (command 1). rsp_ch returns exactly one response per
// request, in order: an event code, the held heater/fan drive, the converted
// temperature on a control event, the current setpoint and the echoed byte.
// A request accepted at a clock edge is held in an input register and worked on
// there, and its response is registered in the response register on rsp_ch.
// One request per cycle is taken when the response side keeps up; the input
// register and the response register each hold one request.
// When rsp_ch.ready stays low the response register holds its value, the input
// register fills, and req_ch.ready drops until the response is taken.
// Synchronous reset empties both registers, sets the setpoint to 26 degrees,
// leaves entry mode and sets the drive to all off.
`timescale 1ns / 1ps
`default_nettype none

module banded_thermostat_with_setpoint_entry_core
   import bts_pkg::*;
#(
   parameter int ENTRY_CHARS = 7
) (
   input wire logic clock,
   input wire logic reset,
   bts_req_if.sink  req_ch,
   bts_rsp_if.source rsp_ch
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_command_ff;
   logic [7:0] s1_byte_ff;
   logic [9:0] s1_sample_ff;

   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_event_ff;
   logic [2:0] out_band_ff;
   logic [8:0] out_temp_ff;
   logic [5:0] out_setpoint_ff;
   logic [7:0] out_echo_ff;

   logic [2:0] held_band_ff, held_band_in;

   logic          req_fire;
   logic          out_advance;
   logic          s1_fire;
   logic [8:0]    temp;
   logic [9:0]    temp_ext;
   logic [9:0]    sp_ext;
   logic [2:0]    band_new;
   entry_res_type entry_res;

   assign out_advance  = !out_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && out_advance;
   assign req_ch.ready = !s1_valid_ff || out_advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   bts_conv u_conv (
      .sensor_sample (s1_sample_ff),
      .temperature_c (temp)
   );

   bts_entry #(
      .EntryChars (ENTRY_CHARS)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_fire),
      .command     (s1_command_ff),
      .serial_byte (s1_byte_ff),
      .res         (entry_res)
   );

   always_comb begin
      temp_ext = {1'b0, temp};
      sp_ext   = {4'b0, entry_res.setpoint};
      if (temp_ext + 10'd4 <= sp_ext) begin
         band_new = BAND_HEAT;
      end else if (temp_ext <= sp_ext + 10'd4) begin
         band_new = BAND_OFF;
      end else if (temp_ext <= sp_ext + 10'd14) begin
         band_new = BAND_LOW;
      end else if (temp_ext <= sp_ext + 10'd24) begin
         band_new = BAND_MED;
      end else begin
         band_new = BAND_HIGH;
      end
      held_band_in = entry_res.control ? band_new : held_band_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_band_ff <= BAND_OFF;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_fire) begin
            held_band_ff <= held_band_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_command_ff <= req_ch.command;
         s1_byte_ff    <= req_ch.serial_byte;
         s1_sample_ff  <= req_ch.sensor_sample;
      end
      if (s1_fire) begin
         out_event_ff    <= entry_res.control ? EV_CONTROL : entry_res.evt;
         out_band_ff     <= held_band_in;
         out_temp_ff     <= entry_res.control ? temp : 9'd0;
         out_setpoint_ff <= entry_res.setpoint;
         out_echo_ff     <= entry_res.echo;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.event_res     = out_event_ff;
   assign rsp_ch.heater_on     = (out_band_ff == BAND_HEAT);
   assign rsp_ch.fan_on        = (out_band_ff >= BAND_LOW);
   assign rsp_ch.fan_duty      = duty_of_band(out_band_ff);
   assign rsp_ch.fan_band      = out_band_ff;
   assign rsp_ch.temperature_c = out_temp_ff;
   assign rsp_ch.setpoint_c    = out_setpoint_ff;
   assign rsp_ch.echo_byte     = out_echo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bts_conv.sv
// sensor sample to whole degrees, floor(sample * 500 / 1023)
`timescale 1ns / 1ps
`default_nettype none

module bts_conv (
   input  wire logic [9:0] sensor_sample,
   output logic      [8:0] temperature_c
);

   logic [18:0] product;
   logic [18:0] scaled;
   logic [8:0]  quot_est;
   logic [19:0] remainder;

   always_comb begin
      // times 500 as 512 - 8 - 4
      product   = {sensor_sample, 9'b0} - {6'b0, sensor_sample, 3'b0}
                  - {7'b0, sensor_sample, 2'b0};
      // reciprocal of 1023, never above the true quotient and at most one below
      scaled    = product + {10'b0, product[18:10]};
      quot_est  = scaled[18:10];
      remainder = {1'b0, product} - {1'b0, quot_est, 10'b0} + {11'b0, quot_est};
      if (remainder >= 20'd1023) begin
         temperature_c = quot_est + 9'd1;
      end else begin
         temperature_c = quot_est;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bts_entry.sv
// setpoint entry: command bytes, incremental number parse, setpoint register
`timescale 1ns / 1ps
`default_nettype none

module bts_entry
   import bts_pkg::*;
#(
   parameter int EntryChars = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          command,
   input  wire logic [7:0]    serial_byte,
   output entry_res_type      res
);

   localparam int CountWidth = $clog2(EntryChars + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(EntryChars);

   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic                  entry_mode_ff, entry_mode_in;
   logic [CountWidth-1:0] char_count_ff, char_count_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [6:0]            value_ff, value_in;
   logic [5:0]            setpoint_ff, setpoint_in;

   logic        is_start;
   logic        is_term;
   logic        is_blank;
   logic        is_sign;
   logic        is_digit;
   logic [1:0]  phase_work;
   logic [10:0] accum;

   always_comb begin
      is_start = serial_byte inside {8'h78, 8'h58};
      is_term  = serial_byte inside {8'h0D, 8'h0A};
      is_blank = serial_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
      is_sign  = serial_byte inside {8'h2B, 8'h2D};
      is_digit = serial_byte inside {[8'h30:8'h39]};
      accum    = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                 + {7'b0, serial_byte[3:0]};

      entry_mode_in = entry_mode_ff;
      char_count_in = char_count_ff;
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      value_in      = value_ff;
      setpoint_in   = setpoint_ff;
      phase_work    = phase_ff;
      res.evt       = EV_NONE;
      res.echo      = 8'd0;
      res.control   = 1'b0;

      if (!command) begin
         if (is_start) begin
            entry_mode_in = 1'b1;
            char_count_in = '0;
            phase_in      = PH_SKIP;
            negative_in   = 1'b0;
            value_in      = 7'd0;
            res.evt       = EV_ENTRY;
         end else if (entry_mode_ff) begin
            if (is_term) begin
               if (!negative_ff && value_ff >= SETPOINT_MIN && value_ff <= SETPOINT_MAX) begin
                  setpoint_in = value_ff[5:0];
                  res.evt     = EV_ACCEPT;
               end else begin
                  res.evt = EV_REJECT;
               end
               entry_mode_in = 1'b0;
               char_count_in = '0;
               phase_in      = PH_SKIP;
               negative_in   = 1'b0;
               value_in      = 7'd0;
            end else if (char_count_ff < CountMax) begin
               char_count_in = char_count_ff + 1'b1;
               res.echo      = serial_byte;
               res.evt       = EV_ECHO;
               if (phase_ff == PH_SKIP && is_sign) begin
                  negative_in = (serial_byte == 8'h2D);
                  phase_in    = PH_DIGITS;
               end else if (!(phase_ff == PH_SKIP && is_blank)) begin
                  if (phase_ff == PH_SKIP) begin
                     phase_work = PH_DIGITS;
                  end
                  phase_in = phase_work;
                  if (phase_work == PH_DIGITS) begin
                     if (is_digit) begin
                        value_in = (accum > 11'd127) ? 7'd127 : accum[6:0];
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
         end
      end else if (!entry_mode_ff) begin
         res.control = 1'b1;
      end

      res.setpoint = setpoint_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_mode_ff <= 1'b0;
         char_count_ff <= '0;
         phase_ff      <= PH_SKIP;
         negative_ff   <= 1'b0;
         value_ff      <= 7'd0;
         setpoint_ff   <= SETPOINT_RESET;
      end else if (step) begin
         entry_mode_ff <= entry_mode_in;
         char_count_ff <= char_count_in;
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         value_ff      <= value_in;
         setpoint_ff   <= setpoint_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bts_checker.sv
// port-level checks for the thermostat core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bts_checker
   import bts_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_event_res,
   input wire logic       rsp_heater_on,
   input wire logic       rsp_fan_on,
   input wire logic [7:0] rsp_fan_duty,
   input wire logic [2:0] rsp_fan_band,
   input wire logic [8:0] rsp_temperature_c,
   input wire logic [5:0] rsp_setpoint_c,
   input wire logic [7:0] rsp_echo_byte
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_fan_band) && $stable(rsp_temperature_c)
         && $stable(rsp_setpoint_c) && $stable(rsp_echo_byte))
      else $error("response changed while stalled");

   // no response in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // drive outputs agree with the band
   a_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heater_on == (rsp_fan_band == BAND_HEAT))
         && (rsp_fan_on == (rsp_fan_band >= BAND_LOW))
         && (rsp_fan_duty == duty_of_band(rsp_fan_band)))
      else $error("drive outputs disagree with band");

   // temperature only on control, echo only on echo
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res == EV_CONTROL || rsp_temperature_c == 9'd0)
         && (rsp_event_res == EV_ECHO || rsp_echo_byte == 8'd0))
      else $error("unused response field not zero");

   // setpoint stays in its legal range
   a_setpoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_setpoint_c >= 6'd10 && rsp_setpoint_c <= 6'd50)
      else $error("setpoint out of range");

endmodule

bind banded_thermostat_with_setpoint_entry_core bts_checker u_bts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_event_res     (rsp_ch.event_res),
   .rsp_heater_on     (rsp_ch.heater_on),
   .rsp_fan_on        (rsp_ch.fan_on),
   .rsp_fan_duty      (rsp_ch.fan_duty),
   .rsp_fan_band      (rsp_ch.fan_band),
   .rsp_temperature_c (rsp_ch.temperature_c),
   .rsp_setpoint_c    (rsp_ch.setpoint_c),
   .rsp_echo_byte     (rsp_ch.echo_byte)
);

`default_nettype wire
